@@ src/temperature_alarm_fsm_unit_defines.svh @@
// ----------------------------------------------------------------------------
// temperature alarm fsm unit assertion macros
// shared concurrent assertion forms, all reset-qualified
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_ALARM_FSM_UNIT_DEFINES_SVH
`define TEMPERATURE_ALARM_FSM_UNIT_DEFINES_SVH

// same-cycle implication
`define TAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("temperature alarm fsm assertion failed");

// next-cycle implication
`define TAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("temperature alarm fsm assertion failed");

`endif

@@ src/taf_pkg.sv @@
// ----------------------------------------------------------------------------
// taf_pkg
// types, codes and helpers shared by the temperature alarm state machine
// ----------------------------------------------------------------------------
package taf_pkg;

   // sample and threshold width
   localparam int TEMP_WIDTH = 16;
   localparam int STATE_W    = 4;
   localparam int LED_W      = 2;
   localparam int EVENT_W    = 3;
   localparam int CLASS_W    = 3;
   localparam int CSR_IDX_W  = 2;

   // state codes
   localparam logic [STATE_W-1:0] ST_NORM1   = 4'd0;
   localparam logic [STATE_W-1:0] ST_NORM2   = 4'd1;
   localparam logic [STATE_W-1:0] ST_NORM3   = 4'd2;
   localparam logic [STATE_W-1:0] ST_WARNHI1 = 4'd3;
   localparam logic [STATE_W-1:0] ST_WARNHI2 = 4'd4;
   localparam logic [STATE_W-1:0] ST_CRITHI  = 4'd5;
   localparam logic [STATE_W-1:0] ST_WARNLO1 = 4'd6;
   localparam logic [STATE_W-1:0] ST_WARNLO2 = 4'd7;
   localparam logic [STATE_W-1:0] ST_CRITLO  = 4'd8;

   // led patterns
   localparam logic [LED_W-1:0] LED_OFF  = 2'd0;
   localparam logic [LED_W-1:0] LED_SLOW = 2'd1;
   localparam logic [LED_W-1:0] LED_FAST = 2'd2;

   // alarm events
   localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
   localparam logic [EVENT_W-1:0] EV_HI_WARN  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_LO_WARN  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_HI_ALARM = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LO_ALARM = 3'd4;

   // state classes
   localparam logic [CLASS_W-1:0] CL_NORM1  = 3'd0;
   localparam logic [CLASS_W-1:0] CL_NORM2  = 3'd1;
   localparam logic [CLASS_W-1:0] CL_NORM3  = 3'd2;
   localparam logic [CLASS_W-1:0] CL_WARNHI = 3'd3;
   localparam logic [CLASS_W-1:0] CL_CRITHI = 3'd4;
   localparam logic [CLASS_W-1:0] CL_WARNLO = 3'd5;
   localparam logic [CLASS_W-1:0] CL_CRITLO = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HI_CRIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HI_WARN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LO_WARN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LO_CRIT = 2'd3;

   // threshold reset values
   localparam logic signed [TEMP_WIDTH-1:0] HI_CRIT_RST = 16'sd100;
   localparam logic signed [TEMP_WIDTH-1:0] HI_WARN_RST = 16'sd80;
   localparam logic signed [TEMP_WIDTH-1:0] LO_WARN_RST = 16'sd10;
   localparam logic signed [TEMP_WIDTH-1:0] LO_CRIT_RST = 16'sd0;

   typedef struct packed {
      logic signed [TEMP_WIDTH-1:0] temperature;
      logic                         restart;
   } taf_req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] alarm_event;
      logic               pattern_set;
      logic [LED_W-1:0]   blink_pattern;
      logic [CLASS_W-1:0] state_class;
   } taf_rsp_type;

   typedef struct packed {
      logic signed [TEMP_WIDTH-1:0] hi_crit;
      logic signed [TEMP_WIDTH-1:0] hi_warn;
      logic signed [TEMP_WIDTH-1:0] lo_warn;
      logic signed [TEMP_WIDTH-1:0] lo_crit;
   } taf_thresh_type;

   // readable class of a state code, unused codes read as first normal
   function automatic logic [CLASS_W-1:0] class_of_state(input logic [STATE_W-1:0] st);
      logic [CLASS_W-1:0] cl;
      case (st)
         ST_NORM1:   cl = CL_NORM1;
         ST_NORM2:   cl = CL_NORM2;
         ST_NORM3:   cl = CL_NORM3;
         ST_WARNHI1: cl = CL_WARNHI;
         ST_WARNHI2: cl = CL_WARNHI;
         ST_CRITHI:  cl = CL_CRITHI;
         ST_WARNLO1: cl = CL_WARNLO;
         ST_WARNLO2: cl = CL_WARNLO;
         ST_CRITLO:  cl = CL_CRITLO;
         default:    cl = CL_NORM1;
      endcase
      return cl;
   endfunction

endpackage

@@ src/taf_step.sv @@
// ----------------------------------------------------------------------------
// taf_step
// next-state and result logic for one sample, purely combinational
// ----------------------------------------------------------------------------
module taf_step (
   input  logic [taf_pkg::STATE_W-1:0] cur_state,
   input  logic [taf_pkg::LED_W-1:0]   cur_led,
   input  taf_pkg::taf_req_type        req,
   input  taf_pkg::taf_thresh_type     thr,
   output logic [taf_pkg::STATE_W-1:0] next_state,
   output taf_pkg::taf_rsp_type        rsp
);
   import taf_pkg::*;

   logic               ge_hw;
   logic               ge_hc;
   logic               le_lw;
   logic               le_lc;
   logic [EVENT_W-1:0] ev;
   logic [LED_W-1:0]   pat;
   logic               set;

   // threshold compares, all signed
   assign ge_hw = (req.temperature >= thr.hi_warn);
   assign ge_hc = (req.temperature >= thr.hi_crit);
   assign le_lw = (req.temperature <= thr.lo_warn);
   assign le_lc = (req.temperature <= thr.lo_crit);

   // transitions, check order depends on the state
   always_comb begin
      next_state = cur_state;
      pat        = cur_led;
      ev         = EV_NONE;
      set        = 1'b0;
      if (req.restart) begin
         next_state = ST_NORM1;
         pat        = LED_OFF;
         set        = 1'b1;
      end else begin
         case (cur_state)
            ST_NORM1: begin
               if (ge_hw) begin
                  ev = EV_HI_WARN; pat = LED_SLOW; next_state = ST_WARNHI1; set = 1'b1;
               end else if (le_lw) begin
                  ev = EV_LO_WARN; pat = LED_SLOW; next_state = ST_WARNLO1; set = 1'b1;
               end
            end
            ST_NORM2: begin
               // back from low side: low re-entry is silent
               if (ge_hw) begin
                  ev = EV_HI_WARN; pat = LED_SLOW; next_state = ST_WARNHI1; set = 1'b1;
               end else if (le_lw) begin
                  pat = LED_SLOW; next_state = ST_WARNLO1; set = 1'b1;
               end
            end
            ST_NORM3: begin
               // back from high side: high re-entry is silent
               if (le_lw) begin
                  ev = EV_LO_WARN; pat = LED_SLOW; next_state = ST_WARNLO1; set = 1'b1;
               end else if (ge_hw) begin
                  pat = LED_SLOW; next_state = ST_WARNHI1; set = 1'b1;
               end
            end
            ST_WARNHI1: begin
               if (ge_hc) begin
                  ev = EV_HI_ALARM; pat = LED_FAST; next_state = ST_CRITHI; set = 1'b1;
               end else if (!ge_hw) begin
                  pat = LED_OFF; next_state = ST_NORM3; set = 1'b1;
               end
            end
            ST_WARNHI2: begin
               if (!ge_hw) begin
                  pat = LED_OFF; next_state = ST_NORM3; set = 1'b1;
               end else if (ge_hc) begin
                  pat = LED_FAST; next_state = ST_CRITHI; set = 1'b1;
               end
            end
            ST_CRITHI: begin
               if (!ge_hc) begin
                  pat = LED_SLOW; next_state = ST_WARNHI2; set = 1'b1;
               end
            end
            ST_WARNLO1: begin
               if (!le_lw) begin
                  pat = LED_OFF; next_state = ST_NORM2; set = 1'b1;
               end else if (le_lc) begin
                  ev = EV_LO_ALARM; pat = LED_FAST; next_state = ST_CRITLO; set = 1'b1;
               end
            end
            ST_WARNLO2: begin
               if (!le_lw) begin
                  pat = LED_OFF; next_state = ST_NORM2; set = 1'b1;
               end else if (le_lc) begin
                  pat = LED_FAST; next_state = ST_CRITLO; set = 1'b1;
               end
            end
            ST_CRITLO: begin
               if (!le_lc) begin
                  pat = LED_SLOW; next_state = ST_WARNLO2; set = 1'b1;
               end
            end
            default: begin
               // unused code: recover to first normal state
               next_state = ST_NORM1;
               pat        = LED_OFF;
               set        = 1'b1;
            end
         endcase
      end
   end

   // result word
   always_comb begin
      rsp.alarm_event   = ev;
      rsp.pattern_set   = set;
      rsp.blink_pattern = pat;
      rsp.state_class   = class_of_state(next_state);
   end

endmodule

@@ src/temperature_alarm_fsm_unit.sv @@
// ----------------------------------------------------------------------------
// temperature_alarm_fsm_unit
// nine-state temperature alarm machine with hysteresis and led pattern
// ----------------------------------------------------------------------------
// Takes one sample word per cycle while the output is not stalled, and
// returns one result word per sample. A sample is captured into an input
// register, evaluated against the four thresholds in one combinational pass,
// and its result lands in the output register on the edge at which the pipe
// can advance. The state and led registers update on that same edge, so the
// following sample always sees them. The output register holds a result while
// the consumer stalls and the input register keeps accepting as long as the
// pipe can move. Threshold writes take effect on the next edge.
`include "temperature_alarm_fsm_unit_defines.svh"

module temperature_alarm_fsm_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  taf_pkg::taf_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output taf_pkg::taf_rsp_type             rsp_payload,
   input  logic                             csr_we,
   input  logic [taf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [taf_pkg::TEMP_WIDTH-1:0]   csr_wdata
);
   import taf_pkg::*;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   taf_req_type          in_word_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   taf_rsp_type          rsp_word_ff;
   logic [STATE_W-1:0]   fsm_state_ff;
   logic [LED_W-1:0]     led_pattern_ff;
   taf_thresh_type       thresh_ff;
   logic                 advance;
   logic                 fire;
   logic [STATE_W-1:0]   step_state;
   taf_rsp_type          step_rsp;
   logic                 crit_state;
   logic                 norm_state;

   // pipe control
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign fire         = in_valid_ff && advance;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_payload;
      end
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.hi_crit <= HI_CRIT_RST;
         thresh_ff.hi_warn <= HI_WARN_RST;
         thresh_ff.lo_warn <= LO_WARN_RST;
         thresh_ff.lo_crit <= LO_CRIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HI_CRIT: thresh_ff.hi_crit <= csr_wdata;
            CSR_HI_WARN: thresh_ff.hi_warn <= csr_wdata;
            CSR_LO_WARN: thresh_ff.lo_warn <= csr_wdata;
            CSR_LO_CRIT: thresh_ff.lo_crit <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // transition logic
   taf_step u_step (
      .cur_state  (fsm_state_ff),
      .cur_led    (led_pattern_ff),
      .req        (in_word_ff),
      .thr        (thresh_ff),
      .next_state (step_state),
      .rsp        (step_rsp)
   );

   // state and led registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_state_ff   <= ST_NORM1;
         led_pattern_ff <= LED_OFF;
      end else if (fire) begin
         fsm_state_ff   <= step_state;
         led_pattern_ff <= step_rsp.blink_pattern;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

   // state groups for the checks below
   assign crit_state = (fsm_state_ff == ST_CRITHI) || (fsm_state_ff == ST_CRITLO);
   assign norm_state = (fsm_state_ff == ST_NORM1) || (fsm_state_ff == ST_NORM2) ||
                       (fsm_state_ff == ST_NORM3);

   // state code stays within the nine used codes
   `TAF_ASSERT_NOW(a_state_legal, clock, reset, 1'b1, fsm_state_ff <= ST_CRITLO)
   // critical states always blink fast
   `TAF_ASSERT_NOW(a_crit_fast, clock, reset, crit_state, led_pattern_ff == LED_FAST)
   // normal states always have the led off
   `TAF_ASSERT_NOW(a_norm_off, clock, reset, norm_state, led_pattern_ff == LED_OFF)
   // an alarm event always comes with a pattern change
   `TAF_ASSERT_NOW(a_event_sets, clock, reset, rsp_valid_ff && rsp_word_ff.alarm_event != EV_NONE, rsp_word_ff.pattern_set)
   // a result follows every evaluated sample
   `TAF_ASSERT_NEXT(a_fire_rsp, clock, reset, fire, rsp_valid_ff)

endmodule
